// ----- hdl/sha256_pkg.sv -----
// package with types, constants and round tables for the sha-256 engine
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       restart;
    logic       put_byte;
    logic [7:0] byte_val;
    logic       comp_start;
    logic       round_en;
    logic       fold;
    logic       len_add;
    logic [2:0] len_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0]  byte_cnt;
    logic [6:0]  round;
    logic [63:0] bit_len;
  } dp_stat_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic var224, input logic [2:0] i);
    logic [31:0] h;
    case ({var224, i})
      4'd0: h = 32'h6a09e667; 4'd1: h = 32'hbb67ae85; 4'd2: h = 32'h3c6ef372;
      4'd3: h = 32'ha54ff53a; 4'd4: h = 32'h510e527f; 4'd5: h = 32'h9b05688c;
      4'd6: h = 32'h1f83d9ab; 4'd7: h = 32'h5be0cd19; 4'd8: h = 32'hc1059ed8;
      4'd9: h = 32'h367cd507; 4'd10: h = 32'h3070dd17; 4'd11: h = 32'hf70e5939;
      4'd12: h = 32'hffc00b31; 4'd13: h = 32'h68581511; 4'd14: h = 32'h64f98fa7;
      default: h = 32'hbefa4fa4;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hdl/sha256_datapath.sv -----
// datapath: block buffer, schedule, round logic, hash words and length counter
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        variant,
  input  dp_cmd_t     cmd,
  input  logic [2:0]  rd_idx,
  output dp_stat_t    stat,
  output logic [31:0] rd_word
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  cnt_r;
  logic [6:0]  rnd_r;
  logic [63:0] len_r;

  logic [5:0]  r6;
  logic [31:0] wx, wy, lo, hi, wnew, wv, t1, t2;
  logic [1:0]  bpos;
  logic [3:0]  widx;
  logic [31:0] bmask, bval;

  assign r6   = rnd_r[5:0];
  assign wx   = w_r[4'(r6 + 6'd1)];
  assign wy   = w_r[4'(r6 + 6'd14)];
  assign lo   = rotr(wx, 7) ^ rotr(wx, 18) ^ (wx >> 3);
  assign hi   = rotr(wy, 17) ^ rotr(wy, 19) ^ (wy >> 10);
  assign wnew = w_r[r6[3:0]] + lo + w_r[4'(r6 + 6'd9)] + hi;
  assign wv   = (r6 >= 6'd16) ? wnew : w_r[r6[3:0]];
  assign t1   = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
              + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(r6) + wv;
  assign t2   = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
              + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign bpos  = cnt_r[1:0];
  assign widx  = cnt_r[5:2];
  assign bmask = 32'hff000000 >> {bpos, 3'b000};
  assign bval  = {cmd.byte_val, 24'd0} >> {bpos, 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      w_r[widx] <= (w_r[widx] & ~bmask) | bval;
    end else if (cmd.round_en && r6 >= 6'd16) begin
      w_r[r6[3:0]] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_h(variant, 3'(i));
        v_r[i] <= '0;
      end
      cnt_r <= '0;
      rnd_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.put_byte) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (cmd.len_add) begin
        len_r <= len_r + 64'(cmd.len_inc);
      end
      if (cmd.comp_start) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        rnd_r <= '0;
      end
    end
  end

  assign stat.byte_cnt = cnt_r;
  assign stat.round    = rnd_r;
  assign stat.bit_len  = {len_r[60:0], 3'b000};
  assign rd_word       = h_r[rd_idx];

endmodule

// ----- hdl/sha256_ctrl.sv -----
// controller: byte sequencing, padding, compression and digest output
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        variant,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  nb_r, nb_nxt;
  logic [1:0]  bi_r, bi_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  li_r, li_nxt;
  logic [2:0]  oi_r, oi_nxt;
  logic [2:0]  n_in;
  logic [2:0]  last_idx;
  logic [7:0]  len_byte;

  assign n_in     = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign last_idx = variant ? 3'd6 : 3'd7;
  assign len_byte = stat.bit_len[{~li_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      nb_r    <= '0;
      bi_r    <= '0;
      fin_r   <= 1'b0;
      li_r    <= '0;
      oi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      nb_r    <= nb_nxt;
      bi_r    <= bi_nxt;
      fin_r   <= fin_nxt;
      li_r    <= li_nxt;
      oi_r    <= oi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    word_nxt  = word_r;
    nb_nxt    = nb_r;
    bi_nxt    = bi_r;
    fin_nxt   = fin_r;
    li_nxt    = li_r;
    oi_nxt    = oi_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.restart = !rst_n || cfg_we;
    case (state_r)
      ST_IDLE: begin
        // no word is taken in reset or on a register write
        in_stall = cfg_we || !rst_n;
        if (in_valid && !in_stall) begin
          word_nxt     = in_message_word;
          nb_nxt       = n_in;
          bi_nxt       = '0;
          fin_nxt      = in_last;
          cmd.len_add  = 1'b1;
          cmd.len_inc  = n_in;
          state_nxt    = ST_PUT;
        end
      end
      ST_PUT: begin
        if (nb_r == 3'({1'b0, bi_r})) begin
          if (fin_r) begin
            cmd.put_byte = 1'b1;
            cmd.byte_val = PadByte;
            ret_nxt      = ST_PAD;
            state_nxt    = (stat.byte_cnt == 6'(BlockBytes - 1)) ? ST_COMP : ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.put_byte = 1'b1;
          cmd.byte_val = word_r[{~bi_r, 3'b000} +: 8];
          bi_nxt       = bi_r + 2'd1;
          if (bi_r == 2'd3) nb_nxt = '0;
          if (stat.byte_cnt == 6'(BlockBytes - 1)) begin
            ret_nxt   = ST_PUT;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        if (stat.byte_cnt == 6'(LenPos)) begin
          li_nxt    = '0;
          state_nxt = ST_LEN;
        end else begin
          cmd.put_byte = 1'b1;
          if (stat.byte_cnt == 6'(BlockBytes - 1)) begin
            ret_nxt   = ST_PAD;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        cmd.put_byte = 1'b1;
        cmd.byte_val = len_byte;
        li_nxt       = li_r + 3'd1;
        if (li_r == 3'd7) begin
          ret_nxt   = ST_OUT;
          oi_nxt    = '0;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        // ST_COMP loads the working vars; the round counter then counts 0..63
        cmd.comp_start = 1'b1;
        state_nxt      = ST_FOLD;
      end
      ST_FOLD: begin
        if (stat.round == 7'(Rounds)) begin
          cmd.fold  = 1'b1;
          state_nxt = ret_r;
        end else begin
          cmd.round_en = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          oi_nxt = oi_r + 3'd1;
          if (oi_r == last_idx) begin
            cmd.restart = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_IDLE;
    end
  end

  assign out_word_index = oi_r;
  assign out_last_word  = (oi_r == last_idx);

endmodule

// ----- hdl/sha256_hash_engine_unit.sv -----
// top level of the sha-256 / sha-224 hash engine
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | message_word, valid_bytes, last
//  out_    | output    | out_valid/out_stall| digest_word, word_index, last_word
//  cfg_    | input     | cfg_we             | cfg_variant
//
// a word is accepted, written one byte per cycle unless a full block pauses it, then released
// a full 64-byte block is compressed in steps: load, 64 rounds, fold
// the last word adds the pad and length bytes, a second block if needed
// synchronous active-low reset restores the sha-256 initial hash
// a cfg write restarts the engine; out_stall holds the current digest word
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_variant,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic     variant_r, variant_nxt;
  logic     variant_use;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // variant register, new value used directly for the restart load
  assign variant_nxt = cfg_we ? cfg_variant : variant_r;
  assign variant_use = !rst_n ? 1'b0 : variant_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  sha256_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .variant         (variant_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .stat            (stat),
    .cmd             (cmd)
  );

  sha256_datapath u_dp (
    .clk     (clk),
    .variant (variant_use),
    .cmd     (cmd),
    .rd_idx  (out_word_index),
    .stat    (stat),
    .rd_word (out_digest_word)
  );

endmodule

// ----- hdl/sha256_checker.sv -----
// port-level checker for the hash engine, bound to the top level
module sha256_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index))
    else $error("digest word dropped under stall");

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest index skipped");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word |-> out_word_index == 3'd6 || out_word_index == 3'd7)
    else $error("bad last word index");

endmodule

bind sha256_hash_engine_unit sha256_checker u_sha256_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);
